[hw/rtl/router_status_line_parser_defines.svh]
// assertion macros for the status line parser
`ifndef ROUTER_STATUS_LINE_PARSER_DEFINES_SVH
`define ROUTER_STATUS_LINE_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define RSLP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("status line parser check failed");

// next-cycle implication
`define RSLP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("status line parser check failed");

`else

`define RSLP_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define RSLP_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

[hw/rtl/rslp_pkg.sv]
package rslp_pkg;

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [6:0] NUM_SAT  = 7'd127;
    localparam logic [2:0] TLINE_LEN   = 3'd6;
    localparam logic [2:0] KEYWORD_LEN = 3'd4;
    localparam logic [2:0] LEN_MAX     = 3'd7;

    typedef enum logic {
        REQ_BYTE  = 1'b0,
        REQ_QUERY = 1'b1
    } req_type_t;

    typedef enum logic {
        KIND_EVENT = 1'b0,
        KIND_READ  = 1'b1
    } result_kind_t;

    // keyword "XMAP", one character per position
    function automatic logic [7:0] kw_char(input logic [1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            2'd0: ch = 8'h58;
            2'd1: ch = 8'h4D;
            2'd2: ch = 8'h41;
            2'd3: ch = 8'h50;
            default: ch = 8'h58;
        endcase
        return ch;
    endfunction

    // decimal accumulate, saturating at 127
    function automatic logic [6:0] acc_digit(input logic [6:0] v, input logic [3:0] d);
        logic [10:0] n;
        n = 11'(v) * 11'd10 + 11'(d);
        return (n > 11'(NUM_SAT)) ? NUM_SAT : n[6:0];
    endfunction

endpackage

[hw/rtl/router_status_line_parser.sv]
// status line parser for a serial audio router
//
// input channel (s_*): one item per handshake. s_req_type selects between a
// received serial byte (s_rx_byte) and a read of one output's current source
// (s_query_output). result channel (m_*): crosspoint change events and read
// responses, at most one result per input item.
//
// a result is registered on m_* in the cycle after its item is accepted.
// throughput: one item per cycle while m_ready is high; the line parser keeps
// its running state in flip-flops and the crosspoint table is a one-write
// one-read memory whose read data is registered beside the result register.
//
// reset (aresetn low, synchronous): line state cleared, map mode off, every
// table entry reads as source 0 through per-entry valid bits, no result held.
//
// stall: the result register holds while m_ready is low; a new item is taken
// only when the result register is empty or being emptied in the same cycle,
// so no result is ever dropped.
`include "router_status_line_parser_defines.svh"

module router_status_line_parser
    import rslp_pkg::*;
#(
    parameter int NUM_SOURCES = 32,
    parameter int NUM_DESTS   = 32
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    input  logic [7:0]        s_rx_byte,
    input  logic [5:0]        s_query_output,

    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_result_kind,
    output logic [5:0]        m_out_index,
    output logic signed [7:0] m_src_index
);

    localparam int AW = (NUM_DESTS > 1) ? $clog2(NUM_DESTS) : 1;
    localparam int CW = $clog2(NUM_DESTS + 1);

    // crosspoint table and its valid bits
    logic signed [7:0]    table_mem [NUM_DESTS];
    logic [NUM_DESTS-1:0] entry_valid_reg;

    // line parser state
    logic          map_mode_reg,      map_mode_next;
    logic [2:0]    line_length_reg,   line_length_next;
    logic          keyword_match_reg, keyword_match_next;
    logic          tline_ok_reg,      tline_ok_next;
    logic          colon_seen_reg,    colon_seen_next;
    logic [6:0]    first_number_reg,  first_number_next;
    logic [2:0]    first_digits_reg,  first_digits_next;
    logic [6:0]    second_number_reg, second_number_next;
    logic [2:0]    second_digits_reg, second_digits_next;
    logic [6:0]    field_value_reg,   field_value_next;
    logic          field_active_reg,  field_active_next;
    logic          field_numeric_reg, field_numeric_next;
    logic [CW-1:0] field_count_reg,   field_count_next;

    // result register
    logic              m_valid_reg,  m_valid_next;
    logic              kind_reg;
    logic [5:0]        index_reg;
    logic signed [7:0] ev_src_reg;
    logic signed [7:0] rd_data_reg;
    logic              rd_hit_reg;
    logic              rd_range_reg;

    // per-item decode
    logic              accept;
    logic              take_byte;
    logic              take_query;
    logic              is_digit;
    logic [3:0]        digit;
    logic              ev_valid;
    logic [5:0]        ev_index;
    logic [AW-1:0]     ev_addr;
    logic signed [7:0] ev_src;
    logic [AW-1:0]     q_addr;
    logic              q_in_range;
    logic              tline_hit;
    logic [6:0]        tline_out;

    // handshake: space in the result register or it empties this cycle
    assign s_ready    = !m_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;
    assign take_byte  = accept && (s_req_type == REQ_BYTE);
    assign take_query = accept && (s_req_type == REQ_QUERY);

    assign is_digit   = (s_rx_byte >= CH_ZERO) && (s_rx_byte <= CH_NINE);
    assign digit      = 4'(s_rx_byte - CH_ZERO);

    assign q_in_range = {1'b0, s_query_output} < 7'(NUM_DESTS);
    assign q_addr     = AW'(s_query_output);

    // complete "T" line: one colon, digits both sides, values in range
    assign tline_out = second_number_reg - 7'd1;
    assign tline_hit = tline_ok_reg && (line_length_reg == TLINE_LEN) && colon_seen_reg
                    && (first_digits_reg != 3'd0) && (second_digits_reg != 3'd0)
                    && (first_number_reg != 7'd0) && (second_number_reg != 7'd0)
                    && ({1'b0, first_number_reg} <= 8'(NUM_SOURCES))
                    && ({1'b0, second_number_reg} <= 8'(NUM_DESTS));

    always_comb begin
        map_mode_next      = map_mode_reg;
        line_length_next   = line_length_reg;
        keyword_match_next = keyword_match_reg;
        tline_ok_next      = tline_ok_reg;
        colon_seen_next    = colon_seen_reg;
        first_number_next  = first_number_reg;
        first_digits_next  = first_digits_reg;
        second_number_next = second_number_reg;
        second_digits_next = second_digits_reg;
        field_value_next   = field_value_reg;
        field_active_next  = field_active_reg;
        field_numeric_next = field_numeric_reg;
        field_count_next   = field_count_reg;
        ev_valid           = 1'b0;
        ev_index           = 6'(field_count_reg);
        ev_addr            = AW'(field_count_reg);
        ev_src             = field_numeric_reg ? $signed({1'b0, field_value_reg} - 8'd1)
                                               : -8'sd1;

        if (take_byte) begin
            if (s_rx_byte == CH_LF) begin
                // end of line: map field close, keyword arm or T line update
                if (map_mode_reg) begin
                    map_mode_next = 1'b0;
                    if (field_active_reg && (field_count_reg < CW'(NUM_DESTS))) begin
                        ev_valid = 1'b1;
                    end
                end else if (keyword_match_reg && (line_length_reg == KEYWORD_LEN)) begin
                    map_mode_next = 1'b1;
                end else if (tline_hit) begin
                    ev_valid = 1'b1;
                    ev_index = 6'(tline_out);
                    ev_addr  = AW'(tline_out);
                    ev_src   = $signed({1'b0, first_number_reg} - 8'd1);
                end
                line_length_next   = 3'd0;
                keyword_match_next = 1'b1;
                tline_ok_next      = 1'b1;
                colon_seen_next    = 1'b0;
                first_number_next  = 7'd0;
                first_digits_next  = 3'd0;
                second_number_next = 7'd0;
                second_digits_next = 3'd0;
                field_value_next   = 7'd0;
                field_active_next  = 1'b0;
                field_numeric_next = 1'b1;
                field_count_next   = '0;
            end else if (s_rx_byte != CH_CR) begin
                if (line_length_reg < KEYWORD_LEN) begin
                    if (s_rx_byte != kw_char(line_length_reg[1:0])) begin
                        keyword_match_next = 1'b0;
                    end
                end else begin
                    keyword_match_next = 1'b0;
                end

                if (line_length_reg == 3'd0) begin
                    if (s_rx_byte != CH_T) begin
                        tline_ok_next = 1'b0;
                    end
                end else if (line_length_reg < TLINE_LEN) begin
                    if (s_rx_byte == CH_COLON) begin
                        if (colon_seen_reg) begin
                            tline_ok_next = 1'b0;
                        end
                        colon_seen_next = 1'b1;
                    end else if (is_digit) begin
                        if (colon_seen_reg) begin
                            second_number_next = acc_digit(second_number_reg, digit);
                            second_digits_next = second_digits_reg + 3'd1;
                        end else begin
                            first_number_next = acc_digit(first_number_reg, digit);
                            first_digits_next = first_digits_reg + 3'd1;
                        end
                    end else begin
                        tline_ok_next = 1'b0;
                    end
                end else begin
                    tline_ok_next = 1'b0;
                end

                if (map_mode_reg) begin
                    if (s_rx_byte == CH_SPACE) begin
                        // space closes a field; empty fields are skipped
                        if (field_active_reg) begin
                            if (field_count_reg < CW'(NUM_DESTS)) begin
                                ev_valid         = 1'b1;
                                field_count_next = field_count_reg + CW'(1);
                            end
                            field_active_next  = 1'b0;
                            field_numeric_next = 1'b1;
                            field_value_next   = 7'd0;
                        end
                    end else begin
                        field_active_next = 1'b1;
                        if (is_digit) begin
                            field_value_next = acc_digit(field_value_reg, digit);
                        end else begin
                            field_numeric_next = 1'b0;
                        end
                    end
                end

                if (line_length_reg < LEN_MAX) begin
                    line_length_next = line_length_reg + 3'd1;
                end
            end
        end
    end

    // result register occupancy
    always_comb begin
        if (accept) begin
            m_valid_next = take_query || ev_valid;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg       <= 1'b0;
            map_mode_reg      <= 1'b0;
            line_length_reg   <= 3'd0;
            keyword_match_reg <= 1'b1;
            tline_ok_reg      <= 1'b1;
            colon_seen_reg    <= 1'b0;
            first_number_reg  <= 7'd0;
            first_digits_reg  <= 3'd0;
            second_number_reg <= 7'd0;
            second_digits_reg <= 3'd0;
            field_value_reg   <= 7'd0;
            field_active_reg  <= 1'b0;
            field_numeric_reg <= 1'b1;
            field_count_reg   <= '0;
        end else begin
            m_valid_reg       <= m_valid_next;
            map_mode_reg      <= map_mode_next;
            line_length_reg   <= line_length_next;
            keyword_match_reg <= keyword_match_next;
            tline_ok_reg      <= tline_ok_next;
            colon_seen_reg    <= colon_seen_next;
            first_number_reg  <= first_number_next;
            first_digits_reg  <= first_digits_next;
            second_number_reg <= second_number_next;
            second_digits_reg <= second_digits_next;
            field_value_reg   <= field_value_next;
            field_active_reg  <= field_active_next;
            field_numeric_reg <= field_numeric_next;
            field_count_reg   <= field_count_next;
        end
    end

    // entries never written since reset read as source 0
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
        end else if (ev_valid) begin
            entry_valid_reg[ev_addr] <= 1'b1;
        end
    end

    // table write and registered read
    always_ff @(posedge aclk) begin
        if (ev_valid) begin
            table_mem[ev_addr] <= ev_src;
        end
        if (take_query) begin
            rd_data_reg  <= table_mem[q_addr];
            rd_hit_reg   <= q_in_range && entry_valid_reg[q_addr];
            rd_range_reg <= q_in_range;
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg   <= take_query ? KIND_READ : KIND_EVENT;
            index_reg  <= take_query ? s_query_output : ev_index;
            ev_src_reg <= ev_src;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = kind_reg;
    assign m_out_index   = index_reg;

    always_comb begin
        if (kind_reg == KIND_EVENT) begin
            m_src_index = ev_src_reg;
        end else if (rd_hit_reg) begin
            m_src_index = rd_data_reg;
        end else if (rd_range_reg) begin
            m_src_index = 8'sd0;
        end else begin
            m_src_index = -8'sd1;
        end
    end

    // input is refused only while a result waits on a stalled receiver
    `RSLP_ASSERT_IMPL(a_ready_only_blocked_by_stall, aclk, aresetn,
        !s_ready, m_valid && !m_ready)
    // every read request gives a read response next cycle
    `RSLP_ASSERT_NEXT(a_query_answered, aclk, aresetn,
        take_query, m_valid && (m_result_kind == KIND_READ))
    // a line end always leaves map mode if it was armed
    `RSLP_ASSERT_NEXT(a_map_line_clears, aclk, aresetn,
        take_byte && map_mode_reg && (s_rx_byte == CH_LF), !map_mode_reg)
    // change events only name existing outputs
    `RSLP_ASSERT_IMPL(a_event_index_in_range, aclk, aresetn,
        m_valid && (m_result_kind == KIND_EVENT), {1'b0, m_out_index} < 7'(NUM_DESTS))

endmodule
